// File: hw/rtl/sorted_key_table_search_unit_assert.svh
// ----------------------------------------------------------------------------
// Sorted key table search unit assertion macros
// Concurrent checks shared by the search unit RTL.
// ----------------------------------------------------------------------------
`ifndef SORTED_KEY_TABLE_SEARCH_UNIT_ASSERT_SVH
`define SORTED_KEY_TABLE_SEARCH_UNIT_ASSERT_SVH

// Same-cycle check: antecedent implies consequent at the same edge.
`define SKTS_ASSERT_NOW(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle check: antecedent implies consequent at the following edge.
`define SKTS_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/skts_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key table search package
// Table geometry, request types and status codes of the search unit.
// ----------------------------------------------------------------------------
package skts_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int TBL_AW      = $clog2(TABLE_DEPTH);
    // Window bounds must hold TABLE_DEPTH itself.
    localparam int CNT_W       = TBL_AW + 1;

    localparam int KEY_W       = 32;
    localparam int IDX_W       = 8;
    localparam int ECNT_W      = 9;
    localparam int ST_W        = 2;

    // Configuration register indexes
    localparam logic CFG_ENTRY_COUNT = 1'b0;
    localparam logic CFG_KEY_MASK    = 1'b1;

    // Request types
    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    // Status codes
    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_ARG   = 2'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;

    localparam logic [KEY_W-1:0] KEY_MASK_RESET = 32'hFFFF_FF00;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_PROBE = 3'b010,
        S_CMP   = 3'b100
    } t_state;

endpackage

// File: hw/rtl/skts_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module skts_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hw/rtl/sorted_key_table_search_unit.sv
// ----------------------------------------------------------------------------
// Sorted key table search unit
// Binary search over a table of keys kept sorted by their masked part.
// ----------------------------------------------------------------------------
// Usage:
//   Configuration: write i_cfg_index/i_cfg_data with i_cfg_valid; o_cfg_ready
//   is always high. Index 0 sets entry_count, index 1 sets key_mask. Write
//   only while the unit is idle.
//   Requests: a request is taken when i_start is high and o_busy is low.
//   A write request stores i_key_value at i_entry_index; a search request
//   looks up i_key_value masked by key_mask among the first entry_count keys.
//   Results: o_done pulses for one cycle with o_status and o_found_index.
//   The receiver cannot stall; status and index hold until the next result.
//   Timing: a write or a search for key zero answers in the cycle after
//   acceptance and the unit stays ready. A search repeats probes, each a
//   memory read then a compare, until a match or an empty window; o_busy
//   stays high until its result, as the single table read port and the
//   shared compare serve one search at a time.
//   Reset: entry_count clears to 0 and key_mask to 0xFFFFFF00; table
//   contents are not cleared and must be written before being searched.
// ----------------------------------------------------------------------------
module sorted_key_table_search_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // configuration
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_index,
    input  logic [31:0]                 i_cfg_data,
    // request
    input  logic                        i_start,
    output logic                        o_busy,
    input  logic                        i_req_type,
    input  logic [skts_pkg::IDX_W-1:0]  i_entry_index,
    input  logic [skts_pkg::KEY_W-1:0]  i_key_value,
    // result
    output logic                        o_done,
    output logic [skts_pkg::ST_W-1:0]   o_status,
    output logic [skts_pkg::IDX_W-1:0]  o_found_index
);
    import skts_pkg::*;

    `include "sorted_key_table_search_unit_assert.svh"

    t_state             r_state, n_state;
    logic [ECNT_W-1:0]  r_entry_count;
    logic [KEY_W-1:0]   r_key_mask;
    logic [KEY_W-1:0]   r_mkey, n_mkey;
    logic [CNT_W-1:0]   r_lo, n_lo;
    logic [CNT_W-1:0]   r_hi, n_hi;
    logic [TBL_AW-1:0]  r_mid, n_mid;
    logic               r_done, n_done;
    logic [ST_W-1:0]    r_status, n_status;
    logic [IDX_W-1:0]   r_found, n_found;

    logic               accept;
    logic               ram_we;
    logic [31:0]        widx;
    logic [31:0]        cnt32;
    logic [31:0]        mid32;
    logic [CNT_W-1:0]   mid_calc;
    logic [KEY_W-1:0]   rd_key;
    logic [KEY_W-1:0]   ekey;

    assign o_cfg_ready = 1'b1;
    assign o_busy      = (r_state != S_IDLE);
    assign accept      = i_start && !o_busy;

    // table write port
    assign widx   = 32'(i_entry_index);
    assign ram_we = accept && (i_req_type == REQ_WRITE) && (widx < 32'(TABLE_DEPTH));

    assign cnt32    = 32'(r_entry_count);
    assign mid_calc = r_lo + ((r_hi - CNT_W'(1) - r_lo) >> 1);
    assign mid32    = 32'(r_mid);
    assign ekey     = rd_key & r_key_mask;

    skts_ram #(
        .WIDTH (KEY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (widx[TBL_AW-1:0]),
        .i_wdata (i_key_value),
        .i_raddr (n_mid),
        .o_rdata (rd_key)
    );

    always_comb begin
        n_state  = r_state;
        n_mkey   = r_mkey;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_mid    = r_mid;
        n_done   = 1'b0;
        n_status = r_status;
        n_found  = r_found;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    priority if (i_req_type == REQ_WRITE) begin
                        n_done   = 1'b1;
                        n_status = ST_OK;
                        n_found  = '0;
                    end else if (i_key_value == '0) begin
                        n_done   = 1'b1;
                        n_status = ST_BAD_ARG;
                        n_found  = '0;
                    end else begin
                        n_mkey  = i_key_value & r_key_mask;
                        n_lo    = '0;
                        // saturate the count to the table depth
                        n_hi    = (cnt32 > 32'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH)
                                                             : cnt32[CNT_W-1:0];
                        n_state = S_PROBE;
                    end
                end
            end
            S_PROBE: begin
                if (r_lo < r_hi) begin
                    // issue the read at the window midpoint
                    n_mid   = mid_calc[TBL_AW-1:0];
                    n_state = S_CMP;
                end else begin
                    n_done   = 1'b1;
                    n_status = ST_NOT_FOUND;
                    n_found  = '0;
                    n_state  = S_IDLE;
                end
            end
            S_CMP: begin
                priority if (ekey == r_mkey) begin
                    n_done   = 1'b1;
                    n_status = ST_OK;
                    n_found  = mid32[IDX_W-1:0];
                    n_state  = S_IDLE;
                end else if (ekey > r_mkey) begin
                    n_hi    = CNT_W'(r_mid);
                    n_state = S_PROBE;
                end else begin
                    n_lo    = CNT_W'(r_mid) + CNT_W'(1);
                    n_state = S_PROBE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_done        <= 1'b0;
            r_entry_count <= '0;
            r_key_mask    <= KEY_MASK_RESET;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_ENTRY_COUNT: r_entry_count <= i_cfg_data[ECNT_W-1:0];
                    CFG_KEY_MASK:    r_key_mask    <= i_cfg_data;
                    default:         r_key_mask    <= r_key_mask;
                endcase
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        r_mkey   <= n_mkey;
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_mid    <= n_mid;
        r_status <= n_status;
        r_found  <= n_found;
    end

    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_found_index = r_found;

    `SKTS_ASSERT_NOW(a_cmp_window, i_clk, i_rst_n, r_state == S_CMP,
        (CNT_W'(r_mid) >= r_lo) && (CNT_W'(r_mid) < r_hi), "probe outside search window")
    `SKTS_ASSERT_NEXT(a_search_busy, i_clk, i_rst_n,
        accept && (i_req_type == REQ_SEARCH) && (i_key_value != '0),
        o_busy && !o_done, "search request did not start a probe sequence")
    `SKTS_ASSERT_NEXT(a_write_answer, i_clk, i_rst_n,
        accept && (i_req_type == REQ_WRITE),
        o_done && (o_status == ST_OK) && !o_busy, "write request not answered")
    `SKTS_ASSERT_NOW(a_hi_bound, i_clk, i_rst_n, r_state == S_PROBE,
        r_hi <= CNT_W'(TABLE_DEPTH), "upper bound beyond table")

endmodule

// File: tb/sorted_key_table_search_unit_tb.sv
// ----------------------------------------------------------------------------
// Sorted key table search unit testbench
// Fills the key table with keys, sorted but for some scrambled refills, sets entry
// count and key mask, and issues bursts of write and search requests. Each result
// is checked against a fixed answer, ST_OK for writes, or a binary-search model.
// ----------------------------------------------------------------------------
module sorted_key_table_search_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skts_pkg::*;

    localparam int ITEM_TARGET = 1150;
    localparam int STALL_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct packed {
        logic [ST_W-1:0]  status;
        logic [IDX_W-1:0] index;
    } t_answer;

    typedef enum logic {ROW_REQUEST, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind        kind;
        logic             req_type;
        logic [IDX_W-1:0] pos;
        logic [KEY_W-1:0] data;
        logic             reg_index;
        logic             fixed;
        t_answer          answer;
    } t_stim_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic                i_cfg_index = CFG_ENTRY_COUNT;
    logic [31:0]         i_cfg_data = '0;
    logic                i_start = 1'b0;
    logic                o_busy;
    logic                i_req_type = REQ_WRITE;
    logic [IDX_W-1:0]    i_entry_index = '0;
    logic [KEY_W-1:0]    i_key_value = '0;
    logic                o_done;
    logic [ST_W-1:0]     o_status;
    logic [IDX_W-1:0]    o_found_index;

    // Shadow of the table and registers
    logic [KEY_W-1:0]    key_store [TABLE_DEPTH];
    logic [ECNT_W-1:0]   entry_limit = '0;
    logic [KEY_W-1:0]    compare_mask = KEY_MASK_RESET;

    t_answer             answers_due [$];
    t_stim_row           opening_rows [$];
    int                  fail_count = 0;
    int                  requests_taken = 0;
    int                  burst_left = 0;
    int                  stall_cycles = 0;

    sorted_key_table_search_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_req_type    (i_req_type),
        .i_entry_index (i_entry_index),
        .i_key_value   (i_key_value),
        .o_done        (o_done),
        .o_status      (o_status),
        .o_found_index (o_found_index)
    );

    always #2 i_clk = ~i_clk;

    // Same probe order as the hardware: window [lo, hi), midpoint rounded down
    function automatic t_answer lookup_key(input logic [KEY_W-1:0] key);
        t_answer          ans;
        int unsigned      count;
        int unsigned      lo;
        int unsigned      hi;
        int unsigned      mid;
        logic [KEY_W-1:0] mkey;
        logic [KEY_W-1:0] ekey;
        ans.status = ST_NOT_FOUND;
        ans.index  = '0;
        if (key == '0) begin
            ans.status = ST_BAD_ARG;
            return ans;
        end
        count = (entry_limit > TABLE_DEPTH) ? TABLE_DEPTH : entry_limit;
        mkey  = key & compare_mask;
        lo    = 0;
        hi    = count;
        while (lo < hi) begin
            mid  = lo + (hi - 1 - lo) / 2;
            ekey = key_store[mid] & compare_mask;
            if (ekey == mkey) begin
                ans.status = ST_OK;
                ans.index  = IDX_W'(mid);
                return ans;
            end
            if (ekey > mkey) begin
                hi = mid;
            end else begin
                lo = mid + 1;
            end
        end
        return ans;
    endfunction

    function automatic t_stim_row request_row(input logic rtype, input int pos,
                                              input logic [KEY_W-1:0] key);
        t_stim_row r;
        r.kind      = ROW_REQUEST;
        r.req_type  = rtype;
        r.pos       = IDX_W'(pos);
        r.data      = key;
        r.reg_index = CFG_ENTRY_COUNT;
        r.fixed     = 1'b0;
        r.answer    = '0;
        return r;
    endfunction

    function automatic t_stim_row known_row(input logic rtype, input int pos,
                                            input logic [KEY_W-1:0] key,
                                            input logic [ST_W-1:0] status);
        t_stim_row r;
        r = request_row(rtype, pos, key);
        r.fixed  = 1'b1;
        r.answer = '{status: status, index: '0};
        return r;
    endfunction

    function automatic t_stim_row register_row(input logic reg_index,
                                               input logic [31:0] value);
        t_stim_row r;
        r = request_row(REQ_WRITE, 0, value);
        r.kind      = ROW_CONFIG;
        r.reg_index = reg_index;
        return r;
    endfunction

    // Present one request, hold it until taken, then queue its answer
    task automatic issue_request(input logic rtype, input logic [IDX_W-1:0] pos,
                                 input logic [KEY_W-1:0] key, input logic fixed,
                                 input t_answer fixed_answer);
        int      gap;
        t_answer ans;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 12);
            if (gap > 0) begin
                i_start <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left    = burst_left - 1;
        i_start       <= 1'b1;
        i_req_type    <= rtype;
        i_entry_index <= pos;
        i_key_value   <= key;
        do @(posedge i_clk); while (o_busy);
        if (rtype == REQ_WRITE) begin
            key_store[pos] = key;
            ans = '{status: ST_OK, index: '0};
        end else begin
            ans = lookup_key(key);
        end
        answers_due.push_back(fixed ? fixed_answer : ans);
        requests_taken++;
    endtask

    // Drain all outstanding answers, then write one register
    task automatic write_register(input logic reg_index, input logic [31:0] value);
        i_start <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0 || o_busy);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= reg_index;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (reg_index == CFG_ENTRY_COUNT) begin
            entry_limit = value[ECNT_W-1:0];
        end else begin
            compare_mask = value;
        end
    endtask

    // Result check
    always @(posedge i_clk) begin
        t_answer want;
        if (i_rst_n && o_done) begin
            if (answers_due.size() == 0) begin
                $display("%0t: unexpected result status %0d index %0d",
                         $time, o_status, o_found_index);
                fail_count++;
            end else begin
                want = answers_due.pop_front();
                if (o_status !== want.status) begin
                    $display("%0t: status expected %0d got %0d",
                             $time, want.status, o_status);
                    fail_count++;
                end
                if (o_found_index !== want.index) begin
                    $display("%0t: found_index expected %0d got %0d",
                             $time, want.index, o_found_index);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || (i_cfg_valid && o_cfg_ready) || o_done) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_stim_row        row;
        int               n;
        int               m;
        int               ops;
        int               phase;
        int               pos;
        logic             scramble;
        logic [KEY_W-1:0] span;
        logic [KEY_W-1:0] key;
        logic [KEY_W-1:0] mask;

        // Opening table: empty table, zero key, a small sorted table, mask extremes
        opening_rows.push_back(known_row(REQ_SEARCH, 0, 32'h0, ST_BAD_ARG));
        opening_rows.push_back(known_row(REQ_SEARCH, 0, 32'h1234_5678, ST_NOT_FOUND));
        opening_rows.push_back(known_row(REQ_WRITE, 0, 32'h0000_0100, ST_OK));
        opening_rows.push_back(known_row(REQ_WRITE, 1, 32'h0000_0200, ST_OK));
        opening_rows.push_back(known_row(REQ_WRITE, 2, 32'h0000_0300, ST_OK));
        opening_rows.push_back(known_row(REQ_WRITE, 3, 32'hFFFF_FFFF, ST_OK));
        opening_rows.push_back(known_row(REQ_WRITE, 255, 32'h0, ST_OK));
        opening_rows.push_back(register_row(CFG_ENTRY_COUNT, 32'd4));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h0000_0100));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h0000_01FF));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h0000_00FF));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'hFFFF_FFFF));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h0000_0250));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h0000_0001));
        opening_rows.push_back(register_row(CFG_KEY_MASK, 32'hFFFF_FFFF));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h0000_0300));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h0000_0301));
        opening_rows.push_back(register_row(CFG_KEY_MASK, 32'h0));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h0000_0005));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h8000_0000));
        opening_rows.push_back(register_row(CFG_ENTRY_COUNT, 32'd1));
        opening_rows.push_back(register_row(CFG_KEY_MASK, KEY_MASK_RESET));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h0000_0100));
        opening_rows.push_back(request_row(REQ_SEARCH, 0, 32'h0000_0200));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (opening_rows[r]) begin
            row = opening_rows[r];
            if (row.kind == ROW_CONFIG) begin
                write_register(row.reg_index, row.data);
            end else begin
                issue_request(row.req_type, row.pos, row.data, row.fixed, row.answer);
            end
        end

        // Random phases: a refill (mostly sorted), new registers, then a stream of requests.
        // The first phase writes every table entry, so later counts never reach
        // an entry that was never written.
        phase = 0;
        requests_taken = 0;
        while (requests_taken < ITEM_TARGET) begin
            case (phase)
                0: begin
                    n = 511;
                    mask = 32'hFFFF_FFFF;
                end
                1: begin
                    n = 0;
                    mask = 32'h0;
                end
                2: begin
                    n = 256;
                    mask = KEY_MASK_RESET;
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0: n = 0;
                        1: n = 256;
                        2: n = $urandom_range(257, 511);
                        3: n = 1;
                        default: n = $urandom_range(2, 40);
                    endcase
                    case ($urandom_range(0, 7))
                        0: mask = 32'hFFFF_FFFF;
                        1: mask = 32'h0;
                        2: mask = 32'hFFFF_0000;
                        3: mask = $urandom;
                        default: mask = KEY_MASK_RESET;
                    endcase
                end
            endcase
            m = (n > TABLE_DEPTH) ? TABLE_DEPTH : n;
            scramble = (phase != 0) && ($urandom_range(0, 7) == 0);
            span = (m == 0) ? '0 : 32'hFFFF_FFFF / m;
            for (int i = 0; i < m; i++) begin
                key = scramble ? $urandom : KEY_W'(i) * span + $urandom_range(0, span - 1);
                issue_request(REQ_WRITE, IDX_W'(i), key, 1'b0, '0);
            end
            write_register(CFG_ENTRY_COUNT, n);
            write_register(CFG_KEY_MASK, mask);

            ops = $urandom_range(30, 80);
            for (int j = 0; j < ops; j++) begin
                if ($urandom_range(0, 9) == 0) begin
                    issue_request(REQ_WRITE, IDX_W'($urandom_range(0, 255)), $urandom,
                                  1'b0, '0);
                end else begin
                    case ($urandom_range(0, 9))
                        0: key = '0;
                        1: key = $urandom & ~compare_mask;
                        2, 3: key = $urandom;
                        default: begin
                            pos = (m == 0) ? 0 : $urandom_range(0, m - 1);
                            key = key_store[pos] ^ ($urandom & ~compare_mask);
                        end
                    endcase
                    issue_request(REQ_SEARCH, '0, key, 1'b0, '0);
                end
            end
            phase++;
        end

        i_start <= 1'b0;
        do @(posedge i_clk); while (answers_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && answers_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
